// File: rtl/core/djm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djm_pkg: shared types, codes and helpers of the joystick drive mixer
// Constants, configuration and stage types, stick clamp and governor.
// ----------------------------------------------------------------------------
package djm_pkg;

   localparam int PWM_FULL    = 255;   // full-scale PWM command
   localparam int STRAFE_KNEE = 128;   // knee of the strafe-propel curve
   localparam int PCT_FULL    = 100;   // governor percentage at full speed
   // floor(p / 100) as (p * GOV_RECIP) >> GOV_SHIFT, exact for p <= 25500
   localparam int GOV_RECIP   = 5243;
   localparam int GOV_SHIFT   = 19;

   typedef logic signed [8:0] pwm_type;   // signed motor command
   typedef logic        [7:0] mag_type;   // magnitude of a command

   localparam logic signed [15:0] STICK_HI = 16'(PWM_FULL);
   localparam logic signed [15:0] STICK_LO = 16'(-PWM_FULL);
   localparam pwm_type            PWM_POS  = 9'(PWM_FULL);
   localparam pwm_type            PWM_NEG  = 9'(-PWM_FULL);
   localparam mag_type            MAG_FULL = 8'(PWM_FULL);
   localparam mag_type            MAG_KNEE = 8'(STRAFE_KNEE);

   // drive modes; the unused code falls back to tank
   localparam logic [1:0] MODE_TANK    = 2'd0;
   localparam logic [1:0] MODE_AUTO    = 2'd1;
   localparam logic [1:0] MODE_MECANUM = 2'd2;

   // register indexes
   localparam logic CSR_MAX_SPEED  = 1'b0;
   localparam logic CSR_DRIVE_MODE = 1'b1;

   // divisor of the scaling step
   localparam logic [1:0] DIV_FULL     = 2'd0;
   localparam logic [1:0] DIV_KNEE     = 2'd1;
   localparam logic [1:0] DIV_NEG_KNEE = 2'd2;

   // side that takes the scaled value
   localparam logic [1:0] SIDE_NONE  = 2'd0;
   localparam logic [1:0] SIDE_LEFT  = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;

   typedef struct packed {
      mag_type    limit;   // governor limit in PWM counts
      logic [1:0] mode;
   } cfg_type;

   typedef struct packed {
      pwm_type    x;       // clamped turn/strafe axis
      pwm_type    y;       // clamped and governed forward axis
      pwm_type    gx;      // governed x, used when y is zero
      logic       yzero;
      logic       strafe;
      logic       smooth;
      logic [1:0] mode;
   } item_type;

   function automatic pwm_type clamp_full(input logic signed [15:0] v);
      pwm_type r;
      if (v > STICK_HI) begin
         r = PWM_POS;
      end else if (v < STICK_LO) begin
         r = PWM_NEG;
      end else begin
         r = v[8:0];
      end
      return r;
   endfunction

   function automatic mag_type mag_of(input pwm_type v);
      pwm_type n;
      n = -v;
      return v[8] ? n[7:0] : v[7:0];
   endfunction

   function automatic pwm_type govern(input pwm_type v, input mag_type lim);
      pwm_type l;
      pwm_type r;
      l = $signed({1'b0, lim});
      if (mag_of(v) > lim) begin
         r = v[8] ? -l : l;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/djm_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djm_csr: configuration registers of the joystick drive mixer
// Holds drive mode and the governor limit, worked out at write time.
// ----------------------------------------------------------------------------
module djm_csr
   import djm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata,
   output cfg_type    cfg
);

   mag_type     limit_ff, limit_in;
   logic [1:0]  mode_ff, mode_in;
   logic [6:0]  pct;
   logic [14:0] prod;
   logic [27:0] quot;

   // saturate the percentage, scale to counts, divide by 100 via reciprocal
   always_comb begin
      pct  = (csr_wdata > 7'(PCT_FULL)) ? 7'(PCT_FULL) : csr_wdata;
      prod = 15'(pct) * 15'(PWM_FULL);
      quot = (28'(prod) * 28'(GOV_RECIP)) >> GOV_SHIFT;
      limit_in = limit_ff;
      mode_in  = mode_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_SPEED:  limit_in = quot[7:0];
            CSR_DRIVE_MODE: mode_in  = csr_wdata[1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= MAG_FULL;
         mode_ff  <= MODE_TANK;
      end else begin
         limit_ff <= limit_in;
         mode_ff  <= mode_in;
      end
   end

   assign cfg.limit = limit_ff;
   assign cfg.mode  = mode_ff;

endmodule

// File: rtl/core/drive_joystick_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_joystick_mixer: joystick to motor command mixer
// Tank, automotive and mecanum mixing of one stick sample per item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  req     | in        | req_valid / req_ready | stick_x, stick_y, strafe_on,
//          |           |                       | smooth_req
//  rsp     | out       | rsp_valid / rsp_ready | motor_a..d, motors_used,
//          |           |                       | smooth_out
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
//  One item per cycle sustained while rsp_ready stays high; rsp_valid rises
//  once the item has passed the four register stages clamp/govern,
//  multiply, divide, assemble.
//  Each stage holds its own valid bit; a stage advances when it is empty or
//  the stage after it moves, so bubbles close up under a stall and nothing
//  is lost or repeated. Synchronous active-high reset empties the pipeline
//  and loads full speed and tank mode.
//
module drive_joystick_mixer
   import djm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // sample channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_stick_x,
   input  logic signed [15:0] req_stick_y,
   input  logic               req_strafe_on,
   input  logic               req_smooth_req,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [8:0]  rsp_motor_a,
   output logic signed [8:0]  rsp_motor_b,
   output logic signed [8:0]  rsp_motor_c,
   output logic signed [8:0]  rsp_motor_d,
   output logic [2:0]         rsp_motors_used,
   output logic               rsp_smooth_out,
   // configuration
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata
);

   cfg_type cfg;

   djm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------- flow
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   // advance a stage when it is empty or its successor moves
   assign rdy4      = !v4_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ------------------------------------------------ stage 1: clamp, govern
   item_type s1_ff, s1_in;

   always_comb begin
      s1_in.x      = clamp_full(req_stick_x);
      s1_in.y      = govern(clamp_full(req_stick_y), cfg.limit);
      s1_in.gx     = govern(s1_in.x, cfg.limit);
      s1_in.yzero  = (s1_in.y == '0);
      s1_in.strafe = req_strafe_on;
      s1_in.smooth = req_smooth_req;
      s1_in.mode   = cfg.mode;
   end

   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
   end

   // ------------------------------------- stage 2: pick factor, multiply
   item_type           s2_ff;
   logic signed [17:0] prod_ff, prod_in;
   logic [1:0]         div_ff, div_in;
   logic [1:0]         side_ff, side_in;
   mag_type            ax;
   mag_type            num;
   logic               xpos;

   always_comb begin
      ax     = mag_of(s1_ff.x);
      xpos   = !s1_ff.x[8] && (ax != '0);
      num    = '0;
      div_in = DIV_FULL;
      side_in = SIDE_NONE;
      if (!s1_ff.yzero && s1_ff.mode != MODE_AUTO && ax != '0) begin
         if (s1_ff.mode == MODE_MECANUM && s1_ff.strafe) begin
            // strafe-propel: steep region reverses the inner side
            if (ax > MAG_KNEE && ax < MAG_FULL) begin
               num     = MAG_FULL - ax;
               div_in  = DIV_NEG_KNEE;
               side_in = xpos ? SIDE_RIGHT : SIDE_LEFT;
            end else if (ax <= MAG_KNEE) begin
               num     = MAG_KNEE - ax;
               div_in  = DIV_KNEE;
               side_in = xpos ? SIDE_RIGHT : SIDE_LEFT;
            end
         end else begin
            // tank and veer: slow the side towards the turn
            num     = MAG_FULL - ax;
            div_in  = DIV_FULL;
            side_in = xpos ? SIDE_RIGHT : SIDE_LEFT;
         end
      end
      prod_in = $signed({1'b0, num}) * s1_ff.y;
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_ff   <= s1_ff;
         prod_ff <= prod_in;
         div_ff  <= div_in;
         side_ff <= side_in;
      end
   end

   // ------------------------------------- stage 3: divide toward zero
   item_type    s3_ff;
   pwm_type     scaled_ff, scaled_in;
   logic [1:0]  side3_ff;
   logic [16:0] pmag;
   logic [16:0] t255;
   mag_type     quo;
   logic        qneg;
   logic signed [17:0] pneg;

   always_comb begin
      pneg = -prod_ff;
      pmag = prod_ff[17] ? pneg[16:0] : prod_ff[16:0];
      // floor(p / 255) = (p + 1 + (p >> 8)) >> 8 for p below 2^16
      t255 = pmag + 17'd1 + (pmag >> 8);
      case (div_ff)
         DIV_FULL:     quo = t255[15:8];
         DIV_KNEE:     quo = 8'(pmag >> 7);
         DIV_NEG_KNEE: quo = 8'(pmag >> 7);
         default:      quo = '0;
      endcase
      qneg      = prod_ff[17] ^ (div_ff == DIV_NEG_KNEE);
      scaled_in = qneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_ff     <= s2_ff;
         scaled_ff <= scaled_in;
         side3_ff  <= side_ff;
      end
   end

   // ------------------------------------- stage 4: assemble the result
   pwm_type    ma_ff, ma_in, mb_ff, mb_in, mc_ff, mc_in, md_ff, md_in;
   logic [2:0] used_ff, used_in;
   logic       smooth_ff;
   pwm_type    left, right, g;

   always_comb begin
      left  = (side3_ff == SIDE_LEFT)  ? scaled_ff : s3_ff.y;
      right = (side3_ff == SIDE_RIGHT) ? scaled_ff : s3_ff.y;
      g     = s3_ff.gx;
      ma_in = '0;
      mb_in = '0;
      mc_in = '0;
      md_in = '0;
      used_in = 3'd2;
      case (s3_ff.mode)
         MODE_AUTO: begin
            ma_in = s3_ff.x;
            mb_in = s3_ff.y;
         end
         MODE_MECANUM: begin
            used_in = 3'd4;
            if (s3_ff.yzero) begin
               if (s3_ff.strafe) begin
                  ma_in = g;  mb_in = -g; mc_in = g;  md_in = -g;
               end else begin
                  ma_in = -g; mb_in = -g; mc_in = g;  md_in = g;
               end
            end else if (!s3_ff.strafe) begin
               ma_in = left;  mb_in = left;  mc_in = right; md_in = right;
            end else if (!s3_ff.y[8]) begin
               ma_in = left;  mb_in = right; mc_in = left;  md_in = right;
            end else begin
               ma_in = right; mb_in = left;  mc_in = right; md_in = left;
            end
         end
         default: begin
            // tank, and the unused code
            if (s3_ff.yzero) begin
               ma_in = g;
               mb_in = -g;
            end else begin
               ma_in = left;
               mb_in = right;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         ma_ff     <= ma_in;
         mb_ff     <= mb_in;
         mc_ff     <= mc_in;
         md_ff     <= md_in;
         used_ff   <= used_in;
         smooth_ff <= s3_ff.smooth;
      end
   end

   assign rsp_motor_a     = ma_ff;
   assign rsp_motor_b     = mb_ff;
   assign rsp_motor_c     = mc_ff;
   assign rsp_motor_d     = md_ff;
   assign rsp_motors_used = used_ff;
   assign rsp_smooth_out  = smooth_ff;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the joystick drive mixer
// Drives stick samples under every drive mode and a range of speed limits,
// mixes each accepted sample into the expected motor commands and compares
// every returned command with the oldest one still due.
// ----------------------------------------------------------------------------
module tb;
   import djm_pkg::*;

   // the spare mode code has no name in the package; it falls back to tank
   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         PHASES       = 8;
   localparam int         PHASE_ITEMS  = 125;
   localparam int         HOLD_AT      = 300;   // results seen before the long hold
   localparam int         HOLD_CYCLES  = 300;
   localparam int         DRAIN_CYCLES = 8;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               strafe;
      logic               smooth;
   } stick_type;

   typedef struct {
      pwm_type    motor_a;
      pwm_type    motor_b;
      pwm_type    motor_c;
      pwm_type    motor_d;
      logic [2:0] motors_used;
      logic       smooth_out;
   } motor_cmd_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_stick_x = '0;
   logic signed [15:0] req_stick_y = '0;
   logic               req_strafe_on = 1'b0;
   logic               req_smooth_req = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [8:0]  rsp_motor_a;
   logic signed [8:0]  rsp_motor_b;
   logic signed [8:0]  rsp_motor_c;
   logic signed [8:0]  rsp_motor_d;
   logic [2:0]         rsp_motors_used;
   logic               rsp_smooth_out;
   logic               csr_we = 1'b0;
   logic               csr_index = 1'b0;
   logic [6:0]         csr_wdata = '0;

   // samples waiting for the bus, and commands owed by the block
   stick_type     pending_sticks[$];
   motor_cmd_type expected_cmds[$];
   stick_type     on_bus;

   // local copy of the register file
   int         cfg_speed = 100;
   logic [1:0] cfg_mode  = MODE_TANK;

   bit calm = 1'b0;   // set for the last phase: no idling on either side
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit held_once = 1'b0;
   int fail_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int settings_used = 0;
   int mode_hits[4] = '{0, 0, 0, 0};
   int cycle_count = 0;

   drive_joystick_mixer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stick_x     (req_stick_x),
      .req_stick_y     (req_stick_y),
      .req_strafe_on   (req_strafe_on),
      .req_smooth_req  (req_smooth_req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_motor_a     (rsp_motor_a),
      .rsp_motor_b     (rsp_motor_b),
      .rsp_motor_c     (rsp_motor_c),
      .rsp_motor_d     (rsp_motor_d),
      .rsp_motors_used (rsp_motors_used),
      .rsp_smooth_out  (rsp_smooth_out),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Expected behaviour
   // ---------------------------------------------------------------------

   // saturate a raw stick reading to full-scale PWM
   function automatic int saturate_stick(input logic signed [15:0] v);
      int s;
      s = v;
      if (s > PWM_FULL) begin
         s = PWM_FULL;
      end else if (s < -PWM_FULL) begin
         s = -PWM_FULL;
      end
      return s;
   endfunction

   // apply the speed governor; anything above 100 percent counts as 100
   function automatic int speed_limited(input int v, input int pct);
      int lim;
      lim = ((pct > PCT_FULL ? PCT_FULL : pct) * PWM_FULL) / PCT_FULL;
      if (v > lim) begin
         return lim;
      end else if (v < -lim) begin
         return -lim;
      end
      return v;
   endfunction

   // exact product, quotient truncated toward zero
   function automatic int scaled(input int v, input int n, input int d);
      return (v * n) / d;
   endfunction

   function automatic motor_cmd_type mix_stick(input stick_type s, input int pct,
                                               input logic [1:0] mode);
      motor_cmd_type cmd;
      int x;
      int y;
      int ax;
      int left;
      int right;
      int used;
      int mo[4];
      x     = saturate_stick(s.x);
      y     = speed_limited(saturate_stick(s.y), pct);
      ax    = x < 0 ? -x : x;
      left  = y;
      right = y;
      used  = 2;
      mo    = '{0, 0, 0, 0};
      case (mode)
         MODE_AUTO: begin
            // steer passes unlimited, throttle governed
            mo[0] = x;
            mo[1] = y;
         end
         MODE_MECANUM: begin
            used = 4;
            if (y == 0) begin
               x = speed_limited(x, pct);
               if (!s.strafe) begin
                  mo = '{-x, -x, x, x};
               end else begin
                  mo = '{x, -x, x, -x};
               end
            end else if (!s.strafe) begin
               // veer: slow the wheels on the side the stick leans to
               if (x > 0) begin
                  right = scaled(right, PWM_FULL - ax, PWM_FULL);
               end else if (x < 0) begin
                  left = scaled(left, PWM_FULL - ax, PWM_FULL);
               end
               mo = '{left, left, right, right};
            end else begin
               // strafe-propel: beyond the knee the scaled side reverses
               if (x > STRAFE_KNEE && x < PWM_FULL) begin
                  right = scaled(right, PWM_FULL - ax, -STRAFE_KNEE);
               end else if (x > 0 && x <= STRAFE_KNEE) begin
                  right = scaled(right, STRAFE_KNEE - ax, STRAFE_KNEE);
               end else if (x < 0 && x >= -STRAFE_KNEE) begin
                  left = scaled(left, STRAFE_KNEE - ax, STRAFE_KNEE);
               end else if (x < -STRAFE_KNEE && x > -PWM_FULL) begin
                  left = scaled(left, PWM_FULL - ax, -STRAFE_KNEE);
               end
               if (y > 0) begin
                  mo = '{left, right, left, right};
               end else begin
                  mo = '{right, left, right, left};
               end
            end
         end
         default: begin
            // tank, and the spare code that falls back to it
            if (y == 0) begin
               x     = speed_limited(x, pct);
               left  = x;
               right = -x;
            end else if (x > 0) begin
               right = scaled(right, PWM_FULL - ax, PWM_FULL);
            end else if (x < 0) begin
               left = scaled(left, PWM_FULL - ax, PWM_FULL);
            end
            mo[0] = left;
            mo[1] = right;
         end
      endcase
      cmd.motor_a     = pwm_type'(mo[0]);
      cmd.motor_b     = pwm_type'(mo[1]);
      cmd.motor_c     = pwm_type'(mo[2]);
      cmd.motor_d     = pwm_type'(mo[3]);
      cmd.motors_used = 3'(used);
      cmd.smooth_out  = s.smooth;
      return cmd;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // one axis reading: favour the interesting points, keep full-width noise
   function automatic logic signed [15:0] random_axis();
      logic signed [15:0] r;
      case ($urandom_range(0, 9))
         0: r = '0;
         1: begin
            case ($urandom_range(0, 11))
               0:       r = 16'sd255;
               1:       r = -16'sd255;
               2:       r = 16'sd128;
               3:       r = -16'sd128;
               4:       r = 16'sd129;
               5:       r = -16'sd129;
               6:       r = 16'sd256;
               7:       r = -16'sd256;
               8:       r = 16'sh7fff;
               9:       r = 16'sh8000;
               10:      r = 16'sd1;
               default: r = -16'sd1;
            endcase
         end
         2, 3: r = 16'($urandom);
         4: begin
            r = 16'($urandom_range(256, 4000));
            if ($urandom_range(0, 1) == 1) begin
               r = -r;
            end
         end
         default: begin
            r = 16'($urandom_range(0, 510));
            r = r - 16'sd255;
         end
      endcase
      return r;
   endfunction

   task automatic queue_stick(input int x, input int y, input logic strafe,
                              input logic smooth);
      stick_type s;
      s.x      = 16'(x);
      s.y      = 16'(y);
      s.strafe = strafe;
      s.smooth = smooth;
      pending_sticks.push_back(s);
   endtask

   task automatic queue_random_stick();
      stick_type s;
      s.x      = random_axis();
      s.y      = random_axis();
      s.strafe = 1'($urandom_range(0, 1));
      s.smooth = 1'($urandom_range(0, 1));
      pending_sticks.push_back(s);
   endtask

   // single register write, one cycle wide; mirror it in the local copy
   task automatic write_csr(input logic idx, input logic [6:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_SPEED) begin
         cfg_speed = data;
      end else begin
         cfg_mode = data[1:0];
      end
   endtask

   task automatic program_regs(input int speed, input logic [6:0] mode_word);
      write_csr(CSR_MAX_SPEED, 7'(speed));
      write_csr(CSR_DRIVE_MODE, mode_word);
      settings_used++;
   endtask

   // hold until every queued item has gone in and come back, then let the
   // pipeline run dry before anything touches the registers
   task automatic settle();
      while (pending_sticks.size() != 0 || req_valid || expected_cmds.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic signed [15:0] want,
                              input logic signed [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: feed the request channel from the pending queue
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         // predict on acceptance, with the registers as they stand now
         if (req_valid && req_ready) begin
            expected_cmds.push_back(mix_stick(on_bus, cfg_speed, cfg_mode));
            mode_hits[cfg_mode]++;
            items_sent++;
         end
         // hold the offered item until it is taken
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_sticks.size() != 0 && !calm
                         && $urandom_range(0, 4) == 0) begin
               // start an idle burst, this one included
               gap_left = $urandom_range(1, 10) - 1;
               req_valid <= 1'b0;
            end else if (pending_sticks.size() != 0) begin
               on_bus = pending_sticks.pop_front();
               req_valid      <= 1'b1;
               req_stick_x    <= on_bus.x;
               req_stick_y    <= on_bus.y;
               req_strafe_on  <= on_bus.strafe;
               req_smooth_req <= on_bus.smooth;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each returned command and pace rsp_ready
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      motor_cmd_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cmds.size() == 0) begin
               $error("motor command returned with none outstanding");
               fail_count++;
            end else begin
               want = expected_cmds.pop_front();
               check_field("motor_a", want.motor_a, rsp_motor_a);
               check_field("motor_b", want.motor_b, rsp_motor_b);
               check_field("motor_c", want.motor_c, rsp_motor_c);
               check_field("motor_d", want.motor_d, rsp_motor_d);
               check_field("motors_used", want.motors_used, rsp_motors_used);
               check_field("smooth_out", want.smooth_out, rsp_smooth_out);
               results_checked++;
            end
         end
         // once, mid-run: block the output long enough for the input to back up
         if (!held_once && results_checked >= HOLD_AT) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: give up well past the slowest legal run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sequence: reset, directed cases per mode, then random phases
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      int speed;
      logic [1:0] mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // tank at full speed: stick extremes, spin in place, both turn sides
      program_regs(100, {5'b10101, MODE_TANK});
      queue_stick(0, 0, 1'b0, 1'b0);
      queue_stick(32767, -32768, 1'b0, 1'b1);
      queue_stick(-32768, 32767, 1'b1, 1'b0);
      queue_stick(100, 0, 1'b0, 1'b1);
      queue_stick(-300, 0, 1'b0, 1'b0);
      queue_stick(255, 200, 1'b0, 1'b1);
      queue_stick(-255, -200, 1'b1, 1'b1);
      queue_stick(-1, 1, 1'b0, 1'b0);
      settle();

      // automotive with the governor shut: steer still passes
      program_regs(0, {5'b01010, MODE_AUTO});
      queue_stick(300, -300, 1'b0, 1'b1);
      queue_stick(-5, 5, 1'b1, 1'b0);
      settle();

      // mecanum at 60 percent: spin, strafe, veer and strafe-propel around the knee
      program_regs(60, {5'b00000, MODE_MECANUM});
      queue_stick(200, 0, 1'b0, 1'b0);
      queue_stick(-200, 0, 1'b1, 1'b1);
      queue_stick(100, 150, 1'b0, 1'b0);
      queue_stick(-100, -150, 1'b0, 1'b1);
      queue_stick(200, 100, 1'b1, 1'b0);
      queue_stick(128, -100, 1'b1, 1'b1);
      queue_stick(-128, 120, 1'b1, 1'b0);
      queue_stick(-200, -255, 1'b1, 1'b1);
      queue_stick(255, 50, 1'b1, 1'b0);
      queue_stick(0, 80, 1'b1, 1'b1);
      queue_stick(129, 255, 1'b1, 1'b0);
      queue_stick(-129, -1, 1'b1, 1'b1);
      settle();

      // random phases; the last one runs with both sides flat out
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       begin speed = 127;                     mode = MODE_TANK;    end
            1:       begin speed = 0;                       mode = MODE_MECANUM; end
            2:       begin speed = 100;                     mode = MODE_MECANUM; end
            3:       begin speed = 1;                       mode = MODE_SPARE;   end
            4:       begin speed = $urandom_range(0, 127); mode = MODE_AUTO;    end
            5:       begin speed = 101;                     mode = MODE_TANK;    end
            6:       begin speed = $urandom_range(0, 127); mode = MODE_MECANUM; end
            default: begin speed = 100;                     mode = MODE_AUTO;    end
         endcase
         calm = (ph == PHASES - 1);
         program_regs(speed, {5'($urandom), mode});
         repeat (PHASE_ITEMS) queue_random_stick();
         settle();
      end

      $display("Mixed %0d stick samples under %0d register settings, %0d commands checked",
               items_sent, settings_used, results_checked);
      $display("Samples per mode: tank %0d, automotive %0d, mecanum %0d, spare %0d",
               mode_hits[MODE_TANK], mode_hits[MODE_AUTO], mode_hits[MODE_MECANUM],
               mode_hits[MODE_SPARE]);
      if (fail_count == 0 && expected_cmds.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
